// ===== rtl/pbrm_pkg.sv =====
// ----------------------------------------------------------------------------
// pbrm_pkg: shared types, constants and helpers for the PCM buffer ring
// Slot count, status and op codes, the result layout and the ring scan helper
// used by the datapath.
// ----------------------------------------------------------------------------
package pbrm_pkg;

   // Ring size and derived widths
   localparam int NUM_SLOTS = 4;
   localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int STEP_W    = IDX_W + 1;
   localparam int SUM_W     = IDX_W + 2;
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_SLOTS - 1);

   // Fixed field widths
   localparam int OP_W    = 3;
   localparam int SLOT_W  = 2;
   localparam int LEN_W   = 16;
   localparam int NUM_W   = 3;
   localparam int TOTAL_W = 32;
   localparam int REQ_W   = 24;
   localparam int RSP_W   = 96;

   // Op codes
   localparam logic [OP_W-1:0] OP_RESERVE = 3'd0;
   localparam logic [OP_W-1:0] OP_PUBLISH = 3'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
   localparam logic [OP_W-1:0] OP_DONE    = 3'd3;
   localparam logic [OP_W-1:0] OP_KICK    = 3'd4;
   localparam logic [OP_W-1:0] OP_TAKE    = 3'd5;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd6;

   // Slot status codes
   localparam logic [1:0] ST_EMPTY   = 2'd0;
   localparam logic [1:0] ST_FILLING = 2'd1;
   localparam logic [1:0] ST_READY   = 2'd2;
   localparam logic [1:0] ST_PLAYING = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load;     // latch the accepted request beat
      logic commit;   // execute the latched op and register the result
   } cmd_type;

   // Result beat, last member in the lowest bits
   typedef struct packed {
      logic [TOTAL_W-1:0] underflow_total;
      logic [TOTAL_W-1:0] done_total;
      logic               drained;
      logic [NUM_W-1:0]   ready_slots;
      logic [NUM_W-1:0]   buffered;
      logic               busy_res;
      logic [LEN_W-1:0]   start_len;
      logic               started;
      logic [SLOT_W-1:0]  slot;
      logic               ok;
   } result_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
   } pick_type;

   // Add a step of at most NUM_SLOTS to a slot index, modulo the ring size
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [STEP_W-1:0] n);
      logic [SUM_W-1:0] sum;
      sum = {2'b00, a} + {1'b0, n};
      if (sum >= SUM_W'(NUM_SLOTS)) begin
         sum = sum - SUM_W'(NUM_SLOTS);
      end
      return sum[IDX_W-1:0];
   endfunction

   // First set bit of mask, scanning from the slot after 'from' around the ring
   function automatic pick_type find_after(input logic [NUM_SLOTS-1:0] mask,
                                           input logic [IDX_W-1:0]     from);
      pick_type         r;
      logic [IDX_W-1:0] i;
      r.hit = 1'b0;
      r.idx = '0;
      for (int n = NUM_SLOTS; n >= 1; n--) begin
         i = wrap_add(from, STEP_W'(n));
         if (mask[i]) begin
            r.hit = 1'b1;
            r.idx = i;
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/pcm_buffer_ring_manager.sv =====
// ----------------------------------------------------------------------------
// pcm_buffer_ring_manager: bookkeeping for a ring of PCM output buffers
// Top level joining the request sequencer and the slot datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request beat per event on the req_ stream: the op code on
//   req_tuser, the slot index, sample count, playing and stream-done flags on
//   req_tdata. Each request yields exactly one result beat on the rsp_ stream
//   with reserve/start information, ring occupancy and the event counters.
//   An accepted beat is latched, then executed once the result register is
//   free; its result is registered and valid from then on. The whole op,
//   including the ring scans over all slots, runs in the execute step;
//   requests are handled one at a time.
//   While rsp_tready is low the result is held; one further request may be
//   accepted and waits in the execute state until the result register frees.
//   Reset (synchronous, active high) empties all slots, zeroes lengths and
//   counters, sets output idle with active slot zero and drops rsp_tvalid.
// ----------------------------------------------------------------------------
module pcm_buffer_ring_manager (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [1:0] slot_idx, [17:2] sample_count, [18] playing, [19] stream_done
   input  logic [pbrm_pkg::REQ_W-1:0]   req_tdata,
   // [2:0] op
   input  logic [pbrm_pkg::OP_W-1:0]    req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [0] ok, [2:1] slot, [3] started, [19:4] start_len, [20] busy_res,
   // [23:21] buffered, [26:24] ready_slots, [27] drained,
   // [59:28] done_total, [91:60] underflow_total
   output logic [pbrm_pkg::RSP_W-1:0]   rsp_tdata
);
   import pbrm_pkg::*;

   cmd_type cmd;

   pbrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   pbrm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== rtl/pbrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbrm_ctrl: request sequencer for the PCM buffer ring
// Accepts one request beat, runs it through the datapath once the result
// register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module pbrm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output pbrm_pkg::cmd_type    cmd
);
   import pbrm_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign out_free   = !valid_ff || rsp_tready;

   // Sequence: wait for a beat, then execute when the result slot frees up
   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               valid_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/pbrm_dp.sv =====
// ----------------------------------------------------------------------------
// pbrm_dp: slot table, ring scans, counters and result register
// Holds the per-slot status and length, the active slot, the output idle flag
// and the two event counters; executes one latched op per commit.
// ----------------------------------------------------------------------------
module pbrm_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  pbrm_pkg::cmd_type            cmd,
   input  logic [pbrm_pkg::REQ_W-1:0]   req_tdata,
   input  logic [pbrm_pkg::OP_W-1:0]    req_tuser,
   output logic [pbrm_pkg::RSP_W-1:0]   rsp_tdata
);
   import pbrm_pkg::*;

   // Latched request
   logic [OP_W-1:0]   op_ff;
   logic [SLOT_W-1:0] bidx_ff;
   logic [LEN_W-1:0]  scount_ff;
   logic              playing_ff;
   logic              sdone_ff;

   // Ring state
   logic [NUM_SLOTS-1:0][1:0]       status_ff, status_in;
   logic [NUM_SLOTS-1:0][LEN_W-1:0] length_ff, length_in;
   logic [IDX_W-1:0]                active_ff, active_in;
   logic                            idle_ff, idle_in;
   logic [TOTAL_W-1:0]              done_ff, done_in;
   logic [TOTAL_W-1:0]              under_ff, under_in;

   result_type result_ff, result_in;

   // Scan inputs
   logic [NUM_SLOTS-1:0] empty_mask;
   logic [NUM_SLOTS-1:0] ready_mask;
   logic [NUM_SLOTS-1:0] chain_mask;
   logic [IDX_W-1:0]     res_from;
   logic [IDX_W-1:0]     sel_idx;
   logic                 idx_ok;
   pick_type             res_pick;
   pick_type             kick_pick;
   pick_type             chain_pick;
   logic [CNT_W-1:0]     n_buffered;
   logic [CNT_W-1:0]     n_ready;

   // Build slot masks from the current table
   always_comb begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
         empty_mask[k] = (status_ff[k] == ST_EMPTY);
         ready_mask[k] = (status_ff[k] == ST_READY) && (length_ff[k] != '0);
         chain_mask[k] = ready_mask[k] && (IDX_W'(k) != active_ff);
      end
   end

   // Reserve scans from slot zero when idle, else from the slot after active
   assign res_from   = idle_ff ? LAST_SLOT : active_ff;
   assign res_pick   = find_after(empty_mask, res_from);
   assign kick_pick  = find_after(ready_mask, active_ff);
   assign chain_pick = find_after(chain_mask, active_ff);
   assign idx_ok     = (int'(bidx_ff) < NUM_SLOTS);
   assign sel_idx    = IDX_W'(bidx_ff);

   // Execute the latched op
   always_comb begin
      status_in  = status_ff;
      length_in  = length_ff;
      active_in  = active_ff;
      idle_in    = idle_ff;
      done_in    = done_ff;
      under_in   = under_ff;
      result_in  = '0;
      n_buffered = '0;
      n_ready    = '0;
      case (op_ff)
         OP_RESERVE: begin
            if (res_pick.hit) begin
               status_in[res_pick.idx] = ST_FILLING;
               result_in.ok            = 1'b1;
               result_in.slot          = SLOT_W'(res_pick.idx);
            end
         end
         OP_PUBLISH: begin
            if (idx_ok && status_ff[sel_idx] == ST_FILLING) begin
               length_in[sel_idx] = scount_ff;
               status_in[sel_idx] = (scount_ff != '0) ? ST_READY : ST_EMPTY;
            end
         end
         OP_RELEASE: begin
            if (idx_ok && status_ff[sel_idx] != ST_PLAYING) begin
               length_in[sel_idx] = '0;
               status_in[sel_idx] = ST_EMPTY;
            end
         end
         OP_DONE: begin
            if (!idle_ff) begin
               done_in              = done_ff + TOTAL_W'(1);
               length_in[active_ff] = '0;
               status_in[active_ff] = ST_EMPTY;
               if (playing_ff && chain_pick.hit) begin
                  // chain straight into the next ready slot
                  status_in[chain_pick.idx] = ST_PLAYING;
                  active_in                 = chain_pick.idx;
                  result_in.slot            = SLOT_W'(chain_pick.idx);
                  result_in.started         = 1'b1;
                  result_in.start_len       = length_ff[chain_pick.idx];
               end else begin
                  active_in = wrap_add(active_ff, STEP_W'(1));
                  idle_in   = 1'b1;
                  if (playing_ff && !sdone_ff) begin
                     under_in = under_ff + TOTAL_W'(1);
                  end
               end
            end
         end
         OP_KICK: begin
            if (idle_ff && playing_ff && kick_pick.hit) begin
               status_in[kick_pick.idx] = ST_PLAYING;
               active_in                = kick_pick.idx;
               idle_in                  = 1'b0;
               result_in.slot           = SLOT_W'(kick_pick.idx);
               result_in.started        = 1'b1;
               result_in.start_len      = length_ff[kick_pick.idx];
            end
         end
         OP_CLEAR: begin
            status_in = '0;
            length_in = '0;
            idle_in   = 1'b1;
            active_in = '0;
         end
         default: begin
         end
      endcase

      // report counters before a take clears them
      result_in.done_total      = done_in;
      result_in.underflow_total = under_in;
      if (op_ff == OP_TAKE) begin
         done_in  = '0;
         under_in = '0;
      end

      // tally the updated table
      for (int k = 0; k < NUM_SLOTS; k++) begin
         if (status_in[k] != ST_EMPTY) begin
            n_buffered = n_buffered + CNT_W'(1);
         end
         if (status_in[k] == ST_READY) begin
            n_ready = n_ready + CNT_W'(1);
         end
      end
      result_in.busy_res    = !idle_in;
      result_in.buffered    = NUM_W'(n_buffered);
      result_in.ready_slots = NUM_W'(n_ready);
      result_in.drained     = idle_in && (n_ready == '0) && sdone_ff;
   end

   // Latch the request beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_tuser;
         bidx_ff    <= req_tdata[1:0];
         scount_ff  <= req_tdata[17:2];
         playing_ff <= req_tdata[18];
         sdone_ff   <= req_tdata[19];
      end
   end

   // Update ring state on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
         length_ff <= '0;
         active_ff <= '0;
         idle_ff   <= 1'b1;
         done_ff   <= '0;
         under_ff  <= '0;
      end else if (cmd.commit) begin
         status_ff <= status_in;
         length_ff <= length_in;
         active_ff <= active_in;
         idle_ff   <= idle_in;
         done_ff   <= done_in;
         under_ff  <= under_in;
      end
   end

   // Hold the result beat until the next commit
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tdata = {{(RSP_W - $bits(result_type)){1'b0}}, result_ff};

endmodule

// ===== verif/pcm_ring_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcm_ring_checker: result checker for the PCM buffer ring manager
// Watches the request and result streams, keeps its own copy of the slot
// ring, predicts one result beat per request beat and compares each result
// beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pcm_ring_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   // [1:0] slot_idx, [17:2] sample_count, [18] playing, [19] stream_done
   input  logic [pbrm_pkg::REQ_W-1:0]   req_tdata,
   // [2:0] op
   input  logic [pbrm_pkg::OP_W-1:0]    req_tuser,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [0] ok, [2:1] slot, [3] started, [19:4] start_len, [20] busy_res,
   // [23:21] buffered, [26:24] ready_slots, [27] drained,
   // [59:28] done_total, [91:60] underflow_total
   input  logic [pbrm_pkg::RSP_W-1:0]   rsp_tdata,
   output int                           fail_count,
   output int                           reports_due,
   output int                           reports_checked,
   output int                           slot_starts
);
   import pbrm_pkg::*;

   localparam int REPORT_W = $bits(result_type);

   // Mirror of the ring state
   logic [1:0]         ring_state [NUM_SLOTS];
   logic [LEN_W-1:0]   ring_len   [NUM_SLOTS];
   int                 playing_slot;
   bit                 output_is_idle;
   logic [TOTAL_W-1:0] completed_count;
   logic [TOTAL_W-1:0] underrun_count;

   // Predicted reports, oldest first
   result_type         ring_reports [$];

   initial begin
      fail_count      = 0;
      reports_due     = 0;
      reports_checked = 0;
      slot_starts     = 0;
   end

   // Empty the ring and set the output idle with slot zero as the playing slot
   task automatic clear_ring_mirror();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         ring_state[i] = ST_EMPTY;
         ring_len[i]   = '0;
      end
      playing_slot   = 0;
      output_is_idle = 1'b1;
   endtask

   // First ready slot with a length, scanning from the slot after 'from'
   function automatic int next_ready_after(input int from);
      int s;
      int found;
      found = -1;
      for (int n = NUM_SLOTS; n >= 1; n--) begin
         s = (from + n) % NUM_SLOTS;
         if (ring_state[s] == ST_READY && ring_len[s] != '0) begin
            found = s;
         end
      end
      return found;
   endfunction

   // Hand a ready slot to the output transfer
   task automatic hand_to_output(input int s, inout result_type r);
      ring_state[s]  = ST_PLAYING;
      playing_slot   = s;
      output_is_idle = 1'b0;
      r.slot         = SLOT_W'(s);
      r.started      = 1'b1;
      r.start_len    = ring_len[s];
   endtask

   // Apply one event to the mirror and build the report it yields
   task automatic compute_ring_report(input logic [OP_W-1:0] op,
                                      input logic [1:0] idx,
                                      input logic [LEN_W-1:0] len,
                                      input logic play,
                                      input logic sdone,
                                      output result_type r);
      int s;
      int first;
      int nx;
      int n_buf;
      int n_ready;
      bit found;
      r = '0;
      case (op)
         OP_RESERVE: begin
            first = output_is_idle ? 0 : (playing_slot + 1) % NUM_SLOTS;
            found = 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               s = (first + i) % NUM_SLOTS;
               if (!found && ring_state[s] == ST_EMPTY) begin
                  ring_state[s] = ST_FILLING;
                  r.ok          = 1'b1;
                  r.slot        = SLOT_W'(s);
                  found         = 1'b1;
               end
            end
         end
         OP_PUBLISH: begin
            if (int'(idx) < NUM_SLOTS && ring_state[idx] == ST_FILLING) begin
               ring_len[idx]   = len;
               ring_state[idx] = (len != '0) ? ST_READY : ST_EMPTY;
            end
         end
         OP_RELEASE: begin
            if (int'(idx) < NUM_SLOTS && ring_state[idx] != ST_PLAYING) begin
               ring_len[idx]   = '0;
               ring_state[idx] = ST_EMPTY;
            end
         end
         OP_DONE: begin
            // Free the finished slot, then chain or go idle
            if (!output_is_idle) begin
               s = playing_slot;
               completed_count++;
               ring_len[s]   = '0;
               ring_state[s] = ST_EMPTY;
               nx = next_ready_after(s);
               if (play && nx >= 0) begin
                  hand_to_output(nx, r);
               end else begin
                  playing_slot   = (s + 1) % NUM_SLOTS;
                  output_is_idle = 1'b1;
                  if (play && !sdone) begin
                     underrun_count++;
                  end
               end
            end
         end
         OP_KICK: begin
            if (output_is_idle && play) begin
               nx = next_ready_after(playing_slot);
               if (nx >= 0) begin
                  hand_to_output(nx, r);
               end
            end
         end
         OP_CLEAR: begin
            clear_ring_mirror();
         end
         default: begin
         end
      endcase

      // Counters are reported before a take clears them
      r.done_total      = completed_count;
      r.underflow_total = underrun_count;
      if (op == OP_TAKE) begin
         completed_count = '0;
         underrun_count  = '0;
      end

      n_buf   = 0;
      n_ready = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (ring_state[i] != ST_EMPTY) n_buf++;
         if (ring_state[i] == ST_READY) n_ready++;
      end
      r.busy_res    = !output_is_idle;
      r.buffered    = NUM_W'(n_buf);
      r.ready_slots = NUM_W'(n_ready);
      r.drained     = output_is_idle && n_ready == 0 && sdone;
   endtask

   task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                              input logic [TOTAL_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Check result beats against predictions, then predict for request beats
   always @(posedge clock) begin : watch_streams
      result_type want;
      result_type got;
      if (reset) begin
         clear_ring_mirror();
         completed_count = '0;
         underrun_count  = '0;
         ring_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[REPORT_W-1:0];
            if (ring_reports.size() == 0) begin
               $display("%0t: result beat with no request pending, got 0x%0h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = ring_reports.pop_front();
               check_field("ok", TOTAL_W'(want.ok), TOTAL_W'(got.ok));
               check_field("slot", TOTAL_W'(want.slot), TOTAL_W'(got.slot));
               check_field("started", TOTAL_W'(want.started), TOTAL_W'(got.started));
               check_field("start_len", TOTAL_W'(want.start_len),
                           TOTAL_W'(got.start_len));
               check_field("busy_res", TOTAL_W'(want.busy_res),
                           TOTAL_W'(got.busy_res));
               check_field("buffered", TOTAL_W'(want.buffered),
                           TOTAL_W'(got.buffered));
               check_field("ready_slots", TOTAL_W'(want.ready_slots),
                           TOTAL_W'(got.ready_slots));
               check_field("drained", TOTAL_W'(want.drained), TOTAL_W'(got.drained));
               check_field("done_total", want.done_total, got.done_total);
               check_field("underflow_total", want.underflow_total,
                           got.underflow_total);
               check_field("padding", '0, TOTAL_W'(rsp_tdata[RSP_W-1:REPORT_W]));
               reports_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            compute_ring_report(req_tuser, req_tdata[1:0], req_tdata[17:2],
                                req_tdata[18], req_tdata[19], want);
            if (want.started) slot_starts++;
            ring_reports.push_back(want);
         end
      end
      reports_due = ring_reports.size();
   end

endmodule

// ===== verif/pcm_buffer_ring_manager_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcm_buffer_ring_manager_tb: stimulus and verdict for the PCM buffer ring
// Runs a directed sequence over every op and corner case, then weighted
// random events under three stall mixes on both streams. A checker module
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module pcm_buffer_ring_manager_tb;
   import pbrm_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE    = 3'd7;
   localparam int              PHASE_ITEMS = 480;
   localparam int              STALL_LIMIT = 4000;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   // [1:0] slot_idx, [17:2] sample_count, [18] playing, [19] stream_done
   logic [REQ_W-1:0]  req_tdata  = '0;
   // [2:0] op
   logic [OP_W-1:0]   req_tuser  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // [0] ok, [2:1] slot, [3] started, [19:4] start_len, [20] busy_res,
   // [23:21] buffered, [26:24] ready_slots, [27] drained,
   // [59:28] done_total, [91:60] underflow_total
   logic [RSP_W-1:0]  rsp_tdata;

   int fail_count;
   int reports_due;
   int reports_checked;
   int slot_starts;
   int sender_gap_pct   = 28;
   int receiver_gap_pct = 77;
   int events_sent      = 0;
   int quiet_cycles     = 0;

   pcm_buffer_ring_manager DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pcm_ring_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .reports_due     (reports_due),
      .reports_checked (reports_checked),
      .slot_starts     (slot_starts)
   );

   always #1 clock = ~clock;

   // Stall the result stream at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_gap_pct);
   end

   // End the run when neither stream moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
         $display("pcm_buffer_ring_manager_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Send one request beat, with a random gap ahead of it
   task automatic send_event(input logic [OP_W-1:0] op, input logic [1:0] idx,
                             input logic [LEN_W-1:0] len, input logic play,
                             input logic sdone);
      if ($urandom_range(99) < sender_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, sdone, play, len, idx};
      do @(posedge clock); while (!req_tready);
      events_sent++;
   endtask

   // Weighted random event: fill, publish and play dominate
   task automatic send_random_event();
      int              pick;
      logic [OP_W-1:0] op;
      logic [LEN_W-1:0] len;
      pick = $urandom_range(99);
      if (pick < 22)      op = OP_RESERVE;
      else if (pick < 46) op = OP_PUBLISH;
      else if (pick < 54) op = OP_RELEASE;
      else if (pick < 74) op = OP_DONE;
      else if (pick < 90) op = OP_KICK;
      else if (pick < 95) op = OP_TAKE;
      else if (pick < 98) op = OP_CLEAR;
      else                op = OP_SPARE;
      case ($urandom_range(9))
         0:       len = '0;
         1:       len = '1;
         default: len = LEN_W'($urandom);
      endcase
      send_event(op, 2'($urandom_range(3)), len, $urandom_range(99) < 85,
                 $urandom_range(99) < 25);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fill the ring, overfill, publish corners, play and drain
      send_event(OP_CLEAR,   2'd0, 16'h0000, 1'b0, 1'b1);
      send_event(OP_RESERVE, 2'd0, 16'h0000, 1'b0, 1'b0);
      send_event(OP_RESERVE, 2'd0, 16'h0000, 1'b0, 1'b0);
      send_event(OP_RESERVE, 2'd0, 16'h0000, 1'b0, 1'b0);
      send_event(OP_RESERVE, 2'd0, 16'h0000, 1'b0, 1'b0);
      send_event(OP_RESERVE, 2'd0, 16'h0000, 1'b0, 1'b0);
      send_event(OP_PUBLISH, 2'd0, 16'hFFFF, 1'b1, 1'b0);
      send_event(OP_PUBLISH, 2'd1, 16'h0000, 1'b1, 1'b0);
      send_event(OP_PUBLISH, 2'd0, 16'h0005, 1'b1, 1'b0);
      send_event(OP_PUBLISH, 2'd2, 16'h0001, 1'b1, 1'b0);
      send_event(OP_DONE,    2'd0, 16'h0000, 1'b1, 1'b0);
      send_event(OP_KICK,    2'd0, 16'h0000, 1'b0, 1'b0);
      send_event(OP_KICK,    2'd0, 16'h0000, 1'b1, 1'b0);
      send_event(OP_KICK,    2'd0, 16'h0000, 1'b1, 1'b0);
      send_event(OP_RELEASE, 2'd2, 16'h0000, 1'b1, 1'b0);
      send_event(OP_RESERVE, 2'd0, 16'h0000, 1'b1, 1'b0);
      send_event(OP_RELEASE, 2'd3, 16'h0000, 1'b1, 1'b0);
      send_event(OP_DONE,    2'd0, 16'h0000, 1'b1, 1'b0);
      send_event(OP_DONE,    2'd0, 16'h0000, 1'b1, 1'b0);
      send_event(OP_SPARE,   2'd3, 16'hFFFF, 1'b1, 1'b1);
      send_event(OP_TAKE,    2'd0, 16'h0000, 1'b1, 1'b0);
      send_event(OP_PUBLISH, 2'd1, 16'hA5A5, 1'b1, 1'b0);
      send_event(OP_KICK,    2'd0, 16'h0000, 1'b1, 1'b0);
      send_event(OP_DONE,    2'd0, 16'h0000, 1'b0, 1'b0);
      send_event(OP_DONE,    2'd0, 16'h0000, 1'b1, 1'b1);

      // Random: three stall mixes, the last with no stalls at all
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            sender_gap_pct   = 77;
            receiver_gap_pct = 28;
         end else if (phase == 2) begin
            sender_gap_pct   = 0;
            receiver_gap_pct = 0;
         end
         repeat (PHASE_ITEMS) send_random_event();
      end
      req_tvalid <= 1'b0;

      // Drain outstanding results, then let the pipeline settle
      do @(negedge clock); while (reports_due != 0);
      repeat (4) @(posedge clock);

      $display("Sent %0d request beats (directed plus three stall mixes); checked %0d results",
               events_sent, reports_checked);
      $display("Slot starts predicted: %0d, field mismatches: %0d",
               slot_starts, fail_count);
      if (fail_count == 0 && reports_due == 0) begin
         $display("pcm_buffer_ring_manager_tb OK");
      end else begin
         $display("pcm_buffer_ring_manager_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pbrm_pkg.sv
rtl/pbrm_ctrl.sv
rtl/pbrm_dp.sv
rtl/pcm_buffer_ring_manager.sv
verif/pcm_ring_checker.sv
verif/pcm_buffer_ring_manager_tb.sv
